// ----- rtl/core/kas_pkg.sv -----
// Shared types and constants for the Kepler anomaly solver.
// Holds the datapath command/status structs and elaboration-time constant helpers.
// No dependencies.
package kas_pkg;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_ROT_INIT,
    OP_ROT_STEP,
    OP_ROT_DONE,
    OP_VEC_INIT,
    OP_VEC_STEP,
    OP_MUL_S,
    OP_MUL_C,
    OP_FD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_UPDATE,
    OP_BETA_DONE,
    OP_SQ_INIT,
    OP_SQ_STEP,
    OP_NU,
    OP_WRAP,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic post;   // final phase: beta in place of eccentricity
  } dp_cmd_t;

  typedef struct packed {
    logic loop_done;
  } dp_stat_t;

  localparam logic CFG_TOLERANCE = 1'b0;
  localparam logic CFG_MAX_ITER  = 1'b1;

  localparam int TOL_W      = 21;
  localparam int ITER_W     = 7;
  localparam int ECC_W      = 16;
  localparam int SQRT_STEPS = 32;
  localparam logic [6:0] TOL_RESET  = 7'd0;
  localparam logic [63:0] PI_Q61    = 64'h6487ED5110B4611A;
  localparam logic [63:0] GAIN_Q32  = 64'd2608131497;

  function automatic logic [63:0] round_q61(logic [63:0] v, int frac);
    int sr;
    sr = 61 - frac;
    return (v + (64'd1 << (sr - 1))) >> sr;
  endfunction

  function automatic logic [63:0] pi_fix(int frac);
    return round_q61(PI_Q61, frac);
  endfunction

  function automatic logic [63:0] gain_fix(int frac);
    int sr;
    logic [63:0] t;
    sr = 32 - frac;
    if (frac < 32) begin
      t = (GAIN_Q32 + (64'd1 << (sr - 1))) >> sr;
    end else begin
      t = GAIN_Q32 << (frac - 32);
    end
    return t;
  endfunction

  // atan(2^-i) as an alternating series at 2^-61, rounded to frac bits
  function automatic logic [63:0] atan_fix(int i, int frac);
    logic [63:0] acc;
    logic [63:0] term;
    int ex;
    acc = 64'd0;
    if (i == 0) begin
      acc = round_q61(PI_Q61 >> 2, frac);
    end else begin
      for (int k = 0; k < 62; k++) begin
        ex = 61 - i * (2 * k + 1);
        if (ex >= 0) begin
          term = (64'd1 << ex) / 64'(2 * k + 1);
          if (k % 2 == 1) acc = acc - term;
          else acc = acc + term;
        end
      end
      acc = round_q61(acc, frac);
    end
    return acc;
  endfunction

endpackage

// ----- rtl/core/kas_ctrl.sv -----
// Sequencer for the Kepler anomaly solver.
// Steps the datapath through Newton iterations and the true-anomaly tail.
// Depends on kas_pkg.
module kas_ctrl #(
  parameter int ROT_STEPS = 32,
  parameter int DIV_STEPS = 32,
  parameter int CW        = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  kas_pkg::dp_stat_t stat,
  output kas_pkg::dp_cmd_t  cmd,
  output logic [CW-1:0]     cnt
);

  typedef enum logic [19:0] {
    S_IDLE      = 20'h00001,
    S_ROT_INIT  = 20'h00002,
    S_ROT_STEP  = 20'h00004,
    S_ROT_DONE  = 20'h00008,
    S_MUL_S     = 20'h00010,
    S_MUL_C     = 20'h00020,
    S_FD        = 20'h00040,
    S_DIV_INIT  = 20'h00080,
    S_DIV_STEP  = 20'h00100,
    S_UPDATE    = 20'h00200,
    S_CHECK     = 20'h00400,
    S_SQ_INIT   = 20'h00800,
    S_SQ_STEP   = 20'h01000,
    S_BETA_DONE = 20'h02000,
    S_VEC_INIT  = 20'h04000,
    S_VEC_STEP  = 20'h08000,
    S_NU        = 20'h10000,
    S_WRAP1     = 20'h20000,
    S_WRAP2     = 20'h40000,
    S_OUT       = 20'h80000
  } state_t;

  state_t        state_r, state_nxt;
  logic          post_r, post_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  kas_pkg::op_t  op;

  always_comb begin
    state_nxt = state_r;
    post_nxt  = post_r;
    cnt_nxt   = '0;
    op        = kas_pkg::OP_NOP;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          op        = kas_pkg::OP_LOAD;
          post_nxt  = 1'b0;
          state_nxt = S_ROT_INIT;
        end
      end
      S_ROT_INIT: begin
        op        = kas_pkg::OP_ROT_INIT;
        state_nxt = S_ROT_STEP;
      end
      S_ROT_STEP: begin
        op      = kas_pkg::OP_ROT_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(ROT_STEPS - 1)) state_nxt = S_ROT_DONE;
      end
      S_ROT_DONE: begin
        op        = kas_pkg::OP_ROT_DONE;
        state_nxt = S_MUL_S;
      end
      S_MUL_S: begin
        op        = kas_pkg::OP_MUL_S;
        state_nxt = S_MUL_C;
      end
      S_MUL_C: begin
        op        = kas_pkg::OP_MUL_C;
        state_nxt = post_r ? S_VEC_INIT : S_FD;
      end
      S_FD: begin
        op        = kas_pkg::OP_FD;
        state_nxt = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        op        = kas_pkg::OP_DIV_INIT;
        state_nxt = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        op      = kas_pkg::OP_DIV_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(DIV_STEPS - 1)) state_nxt = post_r ? S_BETA_DONE : S_UPDATE;
      end
      S_UPDATE: begin
        op        = kas_pkg::OP_UPDATE;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (stat.loop_done) begin
          post_nxt  = 1'b1;
          state_nxt = S_SQ_INIT;
        end else begin
          state_nxt = S_ROT_INIT;
        end
      end
      S_SQ_INIT: begin
        op        = kas_pkg::OP_SQ_INIT;
        state_nxt = S_SQ_STEP;
      end
      S_SQ_STEP: begin
        op      = kas_pkg::OP_SQ_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(kas_pkg::SQRT_STEPS - 1)) state_nxt = S_DIV_INIT;
      end
      S_BETA_DONE: begin
        op        = kas_pkg::OP_BETA_DONE;
        state_nxt = S_ROT_INIT;
      end
      S_VEC_INIT: begin
        op        = kas_pkg::OP_VEC_INIT;
        state_nxt = S_VEC_STEP;
      end
      S_VEC_STEP: begin
        op      = kas_pkg::OP_VEC_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(ROT_STEPS - 1)) state_nxt = S_NU;
      end
      S_NU: begin
        op        = kas_pkg::OP_NU;
        state_nxt = S_WRAP1;
      end
      S_WRAP1: begin
        op        = kas_pkg::OP_WRAP;
        state_nxt = S_WRAP2;
      end
      S_WRAP2: begin
        op        = kas_pkg::OP_WRAP;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        op        = kas_pkg::OP_OUT;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      post_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      post_r  <= post_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign busy     = (state_r != S_IDLE);
  assign cmd.op   = op;
  assign cmd.post = post_r;
  assign cnt      = cnt_r;

endmodule

// ----- rtl/core/kas_dp.sv -----
// Datapath for the Kepler anomaly solver: shared CORDIC, multiplier,
// restoring divider and bit-pair square root, driven by kas_ctrl commands.
// Depends on kas_pkg.
module kas_dp #(
  parameter int ANGLE_WIDTH   = 32,
  parameter int CORDIC_STAGES = 32,
  parameter int CW            = 6
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  kas_pkg::dp_cmd_t          cmd,
  input  logic [CW-1:0]             cnt,
  input  logic [ANGLE_WIDTH-1:0]    in_mean_anomaly,
  input  logic [kas_pkg::ECC_W-1:0] in_eccentricity,
  input  logic [kas_pkg::TOL_W-1:0] tol,
  input  logic [kas_pkg::ITER_W-1:0] cap,
  output kas_pkg::dp_stat_t         stat,
  output logic                      out_valid,
  output logic [ANGLE_WIDTH-1:0]    out_eccentric_anomaly,
  output logic [ANGLE_WIDTH-1:0]    out_true_anomaly,
  output logic                      out_converged,
  output logic [kas_pkg::ITER_W-1:0] out_iterations_used
);

  localparam int F   = ANGLE_WIDTH - 3;
  localparam int SW  = ANGLE_WIDTH + 2;
  localparam int QW  = F + 3;
  localparam int DVW = (F + 6 > 37) ? F + 6 : 37;
  localparam int TIW = $clog2(CORDIC_STAGES);

  localparam logic signed [SW-1:0] PI      = SW'(kas_pkg::pi_fix(F));
  localparam logic signed [SW-1:0] TWO_PI  = PI <<< 1;
  localparam logic signed [SW-1:0] HALF_PI = PI >>> 1;
  localparam logic signed [SW-1:0] ONE     = SW'(1) <<< F;
  localparam logic signed [SW-1:0] GAIN    = SW'(kas_pkg::gain_fix(F));

  logic signed [SW-1:0] tab_w [CORDIC_STAGES];
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_tab
    assign tab_w[g] = SW'(kas_pkg::atan_fix(g, F));
  end

  logic signed [SW-1:0] m_r, ea_r, cx_r, cy_r, cz_r, s_r, c_r, ps_r, pc_r;
  logic signed [SW-1:0] f_r, d_r, beta_r, nu_r;
  logic [kas_pkg::ECC_W-1:0] e16_r;
  logic                 flip_r, dsat_r, conv_r, out_valid_r;
  logic [DVW-1:0]       rem_r, den_r;
  logic [QW-1:0]        quot_r;
  logic [62:0]          sv_r, sres_r;
  logic [kas_pkg::ITER_W-1:0] iter_r, cap_r;

  // combinational helpers
  logic signed [SW-1:0] efix, ld_m, ld_e, ld_ea0;
  logic signed [SW-1:0] rz1, rz2, xs, ys, tv;
  logic                 rflip;
  logic signed [SW-1:0] mul_a, mul_b, mul_r;
  logic [SW-1:0]        mua, mub, mur;
  logic [2*SW-1:0]      mpr;
  logic signed [SW-1:0] dtmp;
  logic [DVW-1:0]       dv_a, dv_den, r2;
  logic [QW:0]          qv;
  logic signed [SW-1:0] qs, ean;
  logic [62:0]          sbit, st;
  logic [5:0]           ssh;
  logic [31:0]          esq;

  assign efix = SW'(e16_r) <<< (F - kas_pkg::ECC_W);
  assign ld_e = SW'(in_eccentricity) <<< (F - kas_pkg::ECC_W);
  assign xs   = cx_r >>> cnt;
  assign ys   = cy_r >>> cnt;
  assign tv   = tab_w[cnt[TIW-1:0]];

  always_comb begin
    ld_m = SW'(in_mean_anomaly);
    if (ld_m > TWO_PI) ld_m = TWO_PI;
    ld_ea0 = (ld_m > PI) ? ld_m - ld_e : ld_m + ld_e;
    if (ld_ea0 < 0) ld_ea0 = '0;
    if (ld_ea0 > TWO_PI) ld_ea0 = TWO_PI;
  end

  // fold the angle into [-pi/2, pi/2] and flip the result sign
  always_comb begin
    rz1   = (ea_r > PI) ? ea_r - TWO_PI : ea_r;
    rflip = 1'b0;
    rz2   = rz1;
    if (rz1 > HALF_PI) begin
      rz2   = rz1 - PI;
      rflip = 1'b1;
    end else if (rz1 < -HALF_PI) begin
      rz2   = rz1 + PI;
      rflip = 1'b1;
    end
  end

  // sign-magnitude product, magnitude truncated to F fraction bits
  always_comb begin
    mul_a = cmd.post ? beta_r : efix;
    mul_b = (cmd.op == kas_pkg::OP_MUL_S) ? s_r : c_r;
    mua   = mul_a[SW-1] ? SW'(-mul_a) : SW'(mul_a);
    mub   = mul_b[SW-1] ? SW'(-mul_b) : SW'(mul_b);
    mpr   = mua * mub;
    mur   = mpr[F+SW-1:F];
    mul_r = (mul_a[SW-1] ^ mul_b[SW-1]) ? -$signed(mur) : $signed(mur);
  end

  always_comb begin
    dtmp = ONE - pc_r;
    if (cmd.post) begin
      dv_a   = DVW'({e16_r, 15'd0});
      dv_den = DVW'((33'd1 << 31) + 33'(sres_r)) << 3;
    end else begin
      dv_a   = f_r[SW-1] ? DVW'(-f_r) : DVW'(f_r);
      dv_den = DVW'(d_r) << 3;
    end
    r2  = rem_r << 1;
    qv  = dsat_r ? ((QW+1)'(8) << F) : {1'b0, quot_r};
    qs  = SW'(qv);
    ean = f_r[SW-1] ? ea_r - qs : ea_r + qs;
    if (ean < 0) ean = '0;
    if (ean > TWO_PI) ean = TWO_PI;
    esq  = e16_r * e16_r;
    ssh  = 6'd62 - {cnt[4:0], 1'b0};
    sbit = 63'd1 << ssh;
    st   = sres_r + sbit;
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      kas_pkg::OP_LOAD: begin
        m_r    <= ld_m;
        e16_r  <= in_eccentricity;
        ea_r   <= ld_ea0;
        iter_r <= '0;
        conv_r <= 1'b0;
        cap_r  <= cap;
      end
      kas_pkg::OP_ROT_INIT: begin
        cx_r   <= GAIN;
        cy_r   <= '0;
        cz_r   <= rz2;
        flip_r <= rflip;
      end
      kas_pkg::OP_ROT_STEP: begin
        if (!cz_r[SW-1]) begin
          cx_r <= cx_r - ys;
          cy_r <= cy_r + xs;
          cz_r <= cz_r - tv;
        end else begin
          cx_r <= cx_r + ys;
          cy_r <= cy_r - xs;
          cz_r <= cz_r + tv;
        end
      end
      kas_pkg::OP_ROT_DONE: begin
        s_r <= flip_r ? -cy_r : cy_r;
        c_r <= flip_r ? -cx_r : cx_r;
      end
      kas_pkg::OP_MUL_S: ps_r <= mul_r;
      kas_pkg::OP_MUL_C: pc_r <= mul_r;
      kas_pkg::OP_FD: begin
        f_r <= m_r - ea_r + ps_r;
        d_r <= (dtmp < SW'(1)) ? SW'(1) : dtmp;
      end
      kas_pkg::OP_DIV_INIT: begin
        rem_r  <= dv_a;
        den_r  <= dv_den;
        quot_r <= '0;
        dsat_r <= (dv_a >= dv_den);
      end
      kas_pkg::OP_DIV_STEP: begin
        if (r2 >= den_r) begin
          rem_r  <= r2 - den_r;
          quot_r <= {quot_r[QW-2:0], 1'b1};
        end else begin
          rem_r  <= r2;
          quot_r <= {quot_r[QW-2:0], 1'b0};
        end
      end
      kas_pkg::OP_UPDATE: begin
        ea_r   <= ean;
        iter_r <= iter_r + 1'b1;
        conv_r <= (SW'(qv) <= SW'(tol));
      end
      kas_pkg::OP_BETA_DONE: beta_r <= qs;
      kas_pkg::OP_SQ_INIT: begin
        sv_r   <= 63'((33'd1 << 32) - 33'(esq)) << 30;
        sres_r <= '0;
      end
      kas_pkg::OP_SQ_STEP: begin
        if (sv_r >= st) begin
          sv_r   <= sv_r - st;
          sres_r <= (sres_r >> 1) + sbit;
        end else begin
          sres_r <= sres_r >> 1;
        end
      end
      kas_pkg::OP_VEC_INIT: begin
        cx_r <= ONE - pc_r;
        cy_r <= ps_r;
        cz_r <= '0;
      end
      kas_pkg::OP_VEC_STEP: begin
        if (!cy_r[SW-1]) begin
          cx_r <= cx_r + ys;
          cy_r <= cy_r - xs;
          cz_r <= cz_r + tv;
        end else begin
          cx_r <= cx_r - ys;
          cy_r <= cy_r + xs;
          cz_r <= cz_r - tv;
        end
      end
      kas_pkg::OP_NU: nu_r <= ea_r + (cz_r <<< 1);
      kas_pkg::OP_WRAP: begin
        if (nu_r < 0) nu_r <= nu_r + TWO_PI;
        else if (nu_r >= TWO_PI) nu_r <= nu_r - TWO_PI;
      end
      kas_pkg::OP_OUT: begin
        out_eccentric_anomaly <= ea_r[ANGLE_WIDTH-1:0];
        out_true_anomaly      <= nu_r[ANGLE_WIDTH-1:0];
        out_converged         <= conv_r;
        out_iterations_used   <= iter_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= (cmd.op == kas_pkg::OP_OUT);
  end

  assign out_valid      = out_valid_r;
  assign stat.loop_done = conv_r || (iter_r >= cap_r);

endmodule

// ----- rtl/core/kepler_anomaly_solver_unit.sv -----
// Kepler equation solver, top level: configuration registers, sequencer, datapath.
// Usage: pulse start with in_mean_anomaly (Q3.29 rad) and in_eccentricity (Q0.16)
// while busy is low; the request is taken on that edge and busy rises.
// Each Newton step runs one CORDIC rotation, two multiplies and a restoring
// divide. The tail adds a square root, a divide, a rotation, two multiplies
// and a vectoring pass; one request at a time.
// The result appears for exactly one cycle with out_valid high, and busy is low
// from that cycle on; the receiver cannot stall and must take it then.
// cfg_we writes tolerance (index 0) or max_iterations (index 1) at once;
// write only while busy is low. Reset sets tolerance 537 and cap 16 and
// returns the block to idle; no clearing pass is needed.
// Depends on kas_pkg, kas_ctrl, kas_dp.
module kepler_anomaly_solver_unit #(
  parameter int ANGLE_WIDTH   = 32,
  parameter int CORDIC_STAGES = 32,
  parameter int ITER_LIMIT    = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [ANGLE_WIDTH-1:0]     in_mean_anomaly,
  input  logic [kas_pkg::ECC_W-1:0]  in_eccentricity,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [kas_pkg::TOL_W-1:0]  cfg_wdata,
  output logic                       out_valid,
  output logic [ANGLE_WIDTH-1:0]     out_eccentric_anomaly,
  output logic [ANGLE_WIDTH-1:0]     out_true_anomaly,
  output logic                       out_converged,
  output logic [kas_pkg::ITER_W-1:0] out_iterations_used
);

  localparam int DIV_STEPS = ANGLE_WIDTH;
  localparam int MAX_A     = (CORDIC_STAGES > DIV_STEPS) ? CORDIC_STAGES : DIV_STEPS;
  localparam int MAX_STEPS = (MAX_A > kas_pkg::SQRT_STEPS) ? MAX_A : kas_pkg::SQRT_STEPS;
  localparam int CW        = $clog2(MAX_STEPS);

  logic [kas_pkg::TOL_W-1:0]  tol_r;
  logic [kas_pkg::ITER_W-1:0] maxit_r, cap;
  kas_pkg::dp_cmd_t           cmd;
  kas_pkg::dp_stat_t          stat;
  logic [CW-1:0]              cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r   <= kas_pkg::TOL_W'(537);
      maxit_r <= kas_pkg::ITER_W'(16);
    end else if (cfg_we) begin
      case (cfg_index)
        kas_pkg::CFG_TOLERANCE: tol_r   <= cfg_wdata;
        kas_pkg::CFG_MAX_ITER:  maxit_r <= cfg_wdata[kas_pkg::ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the cap to 1..ITER_LIMIT
  always_comb begin
    cap = maxit_r;
    if (maxit_r == '0) cap = kas_pkg::ITER_W'(1);
    else if (maxit_r > kas_pkg::ITER_W'(ITER_LIMIT)) cap = kas_pkg::ITER_W'(ITER_LIMIT);
  end

  kas_ctrl #(
    .ROT_STEPS(CORDIC_STAGES),
    .DIV_STEPS(DIV_STEPS),
    .CW(CW)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .stat(stat),
    .cmd(cmd),
    .cnt(cnt)
  );

  kas_dp #(
    .ANGLE_WIDTH(ANGLE_WIDTH),
    .CORDIC_STAGES(CORDIC_STAGES),
    .CW(CW)
  ) u_dp (
    .clk(clk),
    .rst_n(rst_n),
    .cmd(cmd),
    .cnt(cnt),
    .in_mean_anomaly(in_mean_anomaly),
    .in_eccentricity(in_eccentricity),
    .tol(tol_r),
    .cap(cap),
    .stat(stat),
    .out_valid(out_valid),
    .out_eccentric_anomaly(out_eccentric_anomaly),
    .out_true_anomaly(out_true_anomaly),
    .out_converged(out_converged),
    .out_iterations_used(out_iterations_used)
  );

`ifndef SYNTH
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("request taken but block not busy");
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) && !busy)) else $error("result strobe outside a run");
  a_out_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_out_iters: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_iterations_used != '0 &&
                   out_iterations_used <= kas_pkg::ITER_W'(ITER_LIMIT)))
    else $error("iteration count out of range");
`endif

endmodule
